// ----- rtl/seq_window_ack_tracker_defines.svh -----
// Assertion macros for the sequence window tracker.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef SEQ_WINDOW_ACK_TRACKER_DEFINES_SVH
`define SEQ_WINDOW_ACK_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define SWAT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("swat assertion failed");
`define SWAT_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("swat reset assertion failed");
`else
`define SWAT_ASSERT(lbl, clk, rstn, prop)
`define SWAT_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ----- rtl/swat_pkg.sv -----
// Shared types, codes and constants of the sequence window tracker.
// No dependencies; imported by every RTL module of the block.
package swat_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int LIVE_SPAN      = 64;
    localparam int SPAN_W         = $clog2(LIVE_SPAN);
    localparam int SEQ_W          = 32;
    localparam int OUT_SLOT_W     = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int DELAY_W        = 16;
    localparam int GAP_W          = 6;
    localparam int QLIM_W         = 7;

    localparam logic [DELAY_W-1:0] DELAY_RST = 16'd100;
    localparam logic [GAP_W-1:0]   GAP_RST   = 6'd63;
    localparam logic [QLIM_W-1:0]  QLIM_RST  = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_RETX_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd2;

    localparam logic [2:0] REQ_ISSUE   = 3'd0;
    localparam logic [2:0] REQ_REQ_ACK = 3'd1;
    localparam logic [2:0] REQ_CMD_ACK = 3'd2;
    localparam logic [2:0] REQ_FINISH  = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;
    localparam logic [2:0] REQ_RELEASE = 3'd5;

    localparam logic [3:0] K_SEND         = 4'd0;
    localparam logic [3:0] K_WINDOW_FULL  = 4'd1;
    localparam logic [3:0] K_QUEUE_FULL   = 4'd2;
    localparam logic [3:0] K_REQ_ACKED    = 4'd3;
    localparam logic [3:0] K_CMD_ACKED    = 4'd4;
    localparam logic [3:0] K_CMD_FINISHED = 4'd5;
    localparam logic [3:0] K_FINISH_ACK   = 4'd6;
    localparam logic [3:0] K_RETRANSMIT   = 4'd7;
    localparam logic [3:0] K_UNEXPECTED   = 4'd8;
    localparam logic [3:0] K_DUPLICATE    = 4'd9;
    localparam logic [3:0] K_LATE_ACK     = 4'd10;
    localparam logic [3:0] K_RELEASED     = 4'd11;

    localparam logic [1:0] AS_NOT_ACKED = 2'd0;
    localparam logic [1:0] AS_ACKED     = 2'd1;
    localparam logic [1:0] AS_FINISHED  = 2'd2;

    typedef struct packed {
        logic [2:0]       req_type;
        logic             is_command;
        logic             silent_remove;
        logic [7:0]       msg_type;
        logic [SEQ_W-1:0] seq_in;
        logic [SEQ_W-1:0] finish_seq;
        logic [31:0]      ack_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0]            out_kind;
        logic [SEQ_W-1:0]      out_seq;
        logic [OUT_SLOT_W-1:0] out_slot;
        logic                  out_is_command;
        logic [7:0]            out_msg_type;
        logic [31:0]           out_data;
        logic                  out_last;
    } out_item_t;

    typedef enum logic [2:0] {
        RS_QFULL,
        RS_WFULL,
        RS_SEND,
        RS_FINACK,
        RS_LOOK
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     scan_start;
        logic     scan_rd;
        logic     issue_commit;
        logic     look_update;
        logic     tick_inc;
        logic     rs_start;
        logic     rs_mode;
        logic     rs_adv;
        logic     hold_take;
        logic     hold_flush;
        logic     scan_time_set;
        logic     emit;
        logic     last;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       is_command;
        logic       qfull;
        logic       scan_done;
        logic       issue_ok;
        logic       tick_due;
        logic       rx_match;
        logic       rs_last;
        logic       hold_v;
        logic       out_free;
    } ctrl_status_t;

endpackage

// ----- rtl/swat_datapath.sv -----
// Datapath of the sequence window tracker: slot tables, index table, counters,
// result staging. Depends on swat_pkg and the assertion macro header.
`include "seq_window_ack_tracker_defines.svh"

module swat_datapath
    import swat_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_data,
    input  logic                  m_ready,
    output out_item_t             m_data,
    output logic                  m_valid,
    input  ctrl_cmd_t             cmd,
    output ctrl_status_t          status
);

    localparam int SIW = $clog2(SLOT_COUNT);
    localparam int CW  = $clog2(SLOT_COUNT + 1);

    typedef struct packed {
        logic             cmd;
        logic             silent;
        logic [SEQ_W-1:0] seq;
        logic [7:0]       mtype;
        logic [31:0]      sent;
    } slot_info_t;

    logic [DELAY_W-1:0] delay_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [QLIM_W-1:0]  qlim_reg;

    in_item_t           item_reg;
    logic [SEQ_W-1:0]   nseq_reg;
    logic [31:0]        tick_reg;
    logic [31:0]        scan_time_reg;
    logic [QLIM_W-1:0]  pend_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [LIVE_SPAN-1:0]  posv_reg;

    slot_info_t         info_mem [SLOT_COUNT];
    logic [1:0]         st_mem   [SLOT_COUNT];
    logic [SIW-1:0]     pos_mem  [LIVE_SPAN];

    slot_info_t         info_rd_reg;
    logic [1:0]         st_rd_reg;
    logic [SIW-1:0]     pos_rd_reg;
    logic               posv_rd_reg;
    logic [SIW-1:0]     rd_slot_reg;
    logic               rd_ok_reg;

    logic [CW-1:0]      cnt_reg;
    logic               scan_v_reg;
    logic               toold_reg;
    logic               found_reg;
    logic [SIW-1:0]     free_slot_reg;

    logic               tsel_reg;
    logic [SPAN_W-1:0]  off_reg;

    out_item_t          hold_reg;
    logic               hold_v_reg;
    out_item_t          out_reg;
    logic               out_v_reg;

    logic [SPAN_W-1:0]  pos_addr;
    logic [SIW-1:0]     rd_addr;
    logic [SEQ_W-1:0]   rs_target;
    logic [SEQ_W-1:0]   age;
    logic               out_free;
    logic               rd_valid;

    logic               lk_cmd;
    logic               lk_hit;
    logic               lk_wr;
    logic [1:0]         lk_st;
    logic               lk_free;
    out_item_t          lk_res;
    out_item_t          res;
    out_item_t          cand;

    assign rs_target = nseq_reg - SEQ_W'(LIVE_SPAN) + SEQ_W'(off_reg);
    assign pos_addr  = cmd.rs_mode ? rs_target[SPAN_W-1:0] : item_reg.seq_in[SPAN_W-1:0];
    assign rd_addr   = cmd.scan_rd ? cnt_reg[SIW-1:0] : pos_rd_reg;
    assign age       = nseq_reg - info_rd_reg.seq;
    assign out_free  = !out_v_reg || m_ready;
    assign rd_valid  = rd_ok_reg && valid_reg[rd_slot_reg];

    // configuration, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RST;
            gap_reg   <= GAP_RST;
            qlim_reg  <= QLIM_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RETX_DELAY:  delay_reg <= cfg_wdata[DELAY_W-1:0];
                CFG_MAX_GAP:     gap_reg   <= cfg_wdata[GAP_W-1:0];
                CFG_QUEUE_LIMIT: qlim_reg  <= cfg_wdata[QLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
    end

    // memories: one write port and one registered read port each
    always_ff @(posedge aclk) begin
        if (cmd.issue_commit) begin
            info_mem[free_slot_reg] <= '{cmd: item_reg.is_command,
                                         silent: item_reg.silent_remove,
                                         seq: nseq_reg, mtype: item_reg.msg_type,
                                         sent: tick_reg};
        end
        info_rd_reg <= info_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_commit) begin
            st_mem[free_slot_reg] <= AS_NOT_ACKED;
        end else if (cmd.look_update && lk_wr) begin
            st_mem[rd_slot_reg] <= lk_st;
        end
        st_rd_reg <= st_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_commit) begin
            pos_mem[nseq_reg[SPAN_W-1:0]] <= free_slot_reg;
        end
        pos_rd_reg <= pos_mem[pos_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            posv_reg    <= '0;
            posv_rd_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            rd_slot_reg <= '0;
        end else begin
            if (cmd.issue_commit) begin
                posv_reg[nseq_reg[SPAN_W-1:0]] <= 1'b1;
            end
            posv_rd_reg <= posv_reg[pos_addr];
            rd_slot_reg <= rd_addr;
            rd_ok_reg   <= cmd.scan_rd ? (cnt_reg < CW'(SLOT_COUNT))
                                       : (posv_rd_reg && ({1'b0, pos_rd_reg} < CW'(SLOT_COUNT)));
        end
    end

    // sequence, tick and occupancy state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nseq_reg      <= SEQ_W'(1);
            tick_reg      <= '0;
            scan_time_reg <= '0;
            pend_reg      <= '0;
            valid_reg     <= '0;
        end else begin
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + 32'd1;
            end
            if (cmd.scan_time_set) begin
                scan_time_reg <= tick_reg;
            end
            if (cmd.issue_commit) begin
                nseq_reg <= nseq_reg + SEQ_W'(1);
                valid_reg[free_slot_reg] <= 1'b1;
                if (item_reg.is_command) begin
                    pend_reg <= pend_reg + QLIM_W'(1);
                end
            end else if (cmd.look_update && lk_free) begin
                valid_reg[rd_slot_reg] <= 1'b0;
                if (info_rd_reg.cmd && pend_reg != '0) begin
                    pend_reg <= pend_reg - QLIM_W'(1);
                end
            end
        end
    end

    // issue scan: oldest age check and first free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            scan_v_reg    <= 1'b0;
            toold_reg     <= 1'b0;
            found_reg     <= 1'b0;
            free_slot_reg <= '0;
        end else begin
            scan_v_reg <= cmd.scan_rd && (cnt_reg < CW'(SLOT_COUNT));
            if (cmd.scan_start) begin
                cnt_reg   <= '0;
                toold_reg <= 1'b0;
                found_reg <= 1'b0;
            end else if (cmd.scan_rd) begin
                if (cnt_reg < CW'(SLOT_COUNT)) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (scan_v_reg) begin
                    if (valid_reg[rd_slot_reg]) begin
                        if (age > SEQ_W'(gap_reg)) begin
                            toold_reg <= 1'b1;
                        end
                    end else if (!found_reg) begin
                        found_reg     <= 1'b1;
                        free_slot_reg <= rd_slot_reg;
                    end
                end
            end
        end
    end

    // retransmit walk position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsel_reg <= 1'b0;
            off_reg  <= '0;
        end else if (cmd.rs_start) begin
            tsel_reg <= 1'b0;
            off_reg  <= '0;
        end else if (cmd.rs_adv) begin
            off_reg <= off_reg + SPAN_W'(1);
            if (off_reg == SPAN_W'(LIVE_SPAN - 1)) begin
                tsel_reg <= 1'b1;
            end
        end
    end

    // event lookup decision
    always_comb begin
        case (item_reg.req_type)
            REQ_CMD_ACK, REQ_FINISH: lk_cmd = 1'b1;
            REQ_RELEASE:             lk_cmd = item_reg.is_command;
            default:                 lk_cmd = 1'b0;
        endcase
        lk_hit = rd_valid && (info_rd_reg.cmd == lk_cmd)
                 && (info_rd_reg.seq == item_reg.seq_in);
        lk_res = '{out_kind: K_UNEXPECTED, out_seq: item_reg.seq_in, out_slot: '0,
                   out_is_command: lk_cmd, out_msg_type: '0, out_data: '0,
                   out_last: 1'b0};
        lk_wr   = 1'b0;
        lk_st   = AS_NOT_ACKED;
        lk_free = 1'b0;
        if (lk_hit) begin
            lk_res.out_slot     = OUT_SLOT_W'(rd_slot_reg);
            lk_res.out_msg_type = info_rd_reg.mtype;
            case (item_reg.req_type)
                REQ_REQ_ACK, REQ_CMD_ACK: begin
                    if (st_rd_reg == AS_ACKED) begin
                        lk_res.out_kind = K_DUPLICATE;
                    end else if (st_rd_reg != AS_NOT_ACKED) begin
                        lk_res.out_kind = K_LATE_ACK;
                    end else begin
                        lk_res.out_kind = lk_cmd ? K_CMD_ACKED : K_REQ_ACKED;
                        lk_res.out_data = item_reg.ack_data;
                        lk_wr   = 1'b1;
                        lk_st   = AS_ACKED;
                        lk_free = !lk_cmd && info_rd_reg.silent;
                    end
                end
                REQ_FINISH: begin
                    if (st_rd_reg inside {AS_NOT_ACKED, AS_ACKED}) begin
                        lk_res.out_kind = K_CMD_FINISHED;
                        lk_res.out_data = item_reg.ack_data;
                        lk_wr   = 1'b1;
                        lk_st   = AS_FINISHED;
                        lk_free = info_rd_reg.silent;
                    end else begin
                        lk_res.out_kind = K_DUPLICATE;
                    end
                end
                REQ_RELEASE: begin
                    lk_res.out_kind = K_RELEASED;
                    lk_free = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res = '{out_kind: K_SEND, out_seq: nseq_reg, out_slot: '0,
                out_is_command: item_reg.is_command, out_msg_type: item_reg.msg_type,
                out_data: '0, out_last: 1'b0};
        case (cmd.res_sel)
            RS_QFULL: res.out_kind = K_QUEUE_FULL;
            RS_WFULL: res.out_kind = K_WINDOW_FULL;
            RS_SEND:  res.out_slot = OUT_SLOT_W'(free_slot_reg);
            RS_FINACK: begin
                res.out_kind       = K_FINISH_ACK;
                res.out_seq        = item_reg.finish_seq;
                res.out_is_command = 1'b1;
                res.out_msg_type   = '0;
            end
            RS_LOOK: res = lk_res;
            default: ;
        endcase
        res.out_last = cmd.last;
    end

    assign cand = '{out_kind: K_RETRANSMIT, out_seq: info_rd_reg.seq,
                    out_slot: OUT_SLOT_W'(rd_slot_reg), out_is_command: tsel_reg,
                    out_msg_type: info_rd_reg.mtype, out_data: '0, out_last: 1'b0};

    // hold one retransmit back so the last one of a scan can be marked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (cmd.emit) begin
                out_reg   <= res;
                out_v_reg <= 1'b1;
            end else if (cmd.hold_take && hold_v_reg) begin
                out_reg   <= hold_reg;
                out_v_reg <= 1'b1;
            end else if (cmd.hold_flush && hold_v_reg) begin
                out_reg          <= hold_reg;
                out_reg.out_last <= 1'b1;
                out_v_reg        <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            if (cmd.hold_take) begin
                hold_reg   <= cand;
                hold_v_reg <= 1'b1;
            end else if (cmd.hold_flush) begin
                hold_v_reg <= 1'b0;
            end
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_v_reg;

    assign status.req_type   = item_reg.req_type;
    assign status.is_command = item_reg.is_command;
    assign status.qfull      = pend_reg >= qlim_reg;
    assign status.scan_done  = (cnt_reg == CW'(SLOT_COUNT)) && !scan_v_reg;
    assign status.issue_ok   = !toold_reg && found_reg;
    assign status.tick_due   = (tick_reg - scan_time_reg) >= 32'(delay_reg);
    assign status.rx_match   = rd_valid && (info_rd_reg.cmd == tsel_reg)
                               && (info_rd_reg.seq == rs_target)
                               && (st_rd_reg == AS_NOT_ACKED)
                               && ((tick_reg - info_rd_reg.sent) >= 32'(delay_reg));
    assign status.rs_last    = tsel_reg && (off_reg == SPAN_W'(LIVE_SPAN - 1));
    assign status.hold_v     = hold_v_reg;
    assign status.out_free   = out_free;

    `SWAT_ASSERT(a_emit_free, aclk, aresetn, cmd.emit |-> out_free)
    `SWAT_ASSERT(a_commit_free_slot, aclk, aresetn, cmd.issue_commit |-> !valid_reg[free_slot_reg])
    `SWAT_ASSERT(a_commit_seq, aclk, aresetn, cmd.issue_commit |=> nseq_reg == $past(nseq_reg) + SEQ_W'(1))
    `SWAT_ASSERT(a_hold_kind, aclk, aresetn, hold_v_reg |-> hold_reg.out_kind == K_RETRANSMIT)
    `SWAT_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !out_v_reg && !hold_v_reg)

endmodule

// ----- rtl/swat_ctrl.sv -----
// Controller of the sequence window tracker: one-hot sequencer for issue,
// lookup and retransmit scan. Depends on swat_pkg.
module swat_ctrl
    import swat_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b000000000001,
        ST_DISPATCH = 12'b000000000010,
        ST_ISCAN    = 12'b000000000100,
        ST_IDECIDE  = 12'b000000001000,
        ST_LK_POS   = 12'b000000010000,
        ST_LK_SLOT  = 12'b000000100000,
        ST_LK_EVAL  = 12'b000001000000,
        ST_TK_CHK   = 12'b000010000000,
        ST_RS_POS   = 12'b000100000000,
        ST_RS_SLOT  = 12'b001000000000,
        ST_RS_EVAL  = 12'b010000000000,
        ST_RS_END   = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.res_sel = RS_LOOK;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.req_type)
                    REQ_ISSUE: begin
                        if (status.is_command && status.qfull) begin
                            if (status.out_free) begin
                                cmd.emit    = 1'b1;
                                cmd.last    = 1'b1;
                                cmd.res_sel = RS_QFULL;
                                state_next  = ST_IDLE;
                            end
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_ISCAN;
                        end
                    end
                    REQ_REQ_ACK, REQ_CMD_ACK, REQ_RELEASE: state_next = ST_LK_POS;
                    REQ_FINISH: begin
                        if (status.out_free) begin
                            cmd.emit    = 1'b1;
                            cmd.res_sel = RS_FINACK;
                            state_next  = ST_LK_POS;
                        end
                    end
                    REQ_TICK: begin
                        cmd.tick_inc = 1'b1;
                        state_next   = ST_TK_CHK;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_ISCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_IDECIDE;
                end
            end
            ST_IDECIDE: begin
                if (status.out_free) begin
                    cmd.emit         = 1'b1;
                    cmd.last         = 1'b1;
                    cmd.res_sel      = status.issue_ok ? RS_SEND : RS_WFULL;
                    cmd.issue_commit = status.issue_ok;
                    state_next       = ST_IDLE;
                end
            end
            ST_LK_POS:  state_next = ST_LK_SLOT;
            ST_LK_SLOT: state_next = ST_LK_EVAL;
            ST_LK_EVAL: begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.last        = 1'b1;
                    cmd.look_update = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_TK_CHK: begin
                if (status.tick_due) begin
                    cmd.rs_start = 1'b1;
                    state_next   = ST_RS_POS;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RS_POS: begin
                cmd.rs_mode = 1'b1;
                state_next  = ST_RS_SLOT;
            end
            ST_RS_SLOT: begin
                cmd.rs_mode = 1'b1;
                state_next  = ST_RS_EVAL;
            end
            ST_RS_EVAL: begin
                cmd.rs_mode = 1'b1;
                // hold while a held resend cannot move out
                if (!(status.rx_match && status.hold_v && !status.out_free)) begin
                    cmd.hold_take = status.rx_match;
                    cmd.rs_adv    = 1'b1;
                    state_next    = status.rs_last ? ST_RS_END : ST_RS_POS;
                end
            end
            ST_RS_END: begin
                if (!status.hold_v || status.out_free) begin
                    cmd.hold_flush    = status.hold_v;
                    cmd.scan_time_set = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/seq_window_ack_tracker.sv -----
// Top level of the sequence window tracker: sequencer plus slot datapath.
// Depends on swat_pkg, swat_ctrl and swat_datapath.
//
// Usage: events enter on the s_ channel (valid/ready, one beat per event) and
// results leave on the m_ channel, one beat each, out_last marking the final
// beat caused by an event; ticks without a due scan give no beat at all.
// Registers are written through cfg_we/cfg_index/cfg_wdata with no wait; the user
// must write them only while the block is idle, which the block does not enforce.
// Work per event, from accept to the last result loaded:
//   issue: a walk over the slot table that checks the oldest live number
//          and finds the first free slot;
//   ack, finish, release: a read of the index table, then of the slot table;
//   tick with a scan: three memory steps for each of 64 age positions in
//          the request pass and the command pass.
// One event is worked on at a time; the next is taken once the last result of
// the previous one sits in the output register. A stalled receiver holds the
// output beat and the sequencer waits on it; up to one retransmit beat is
// held back inside so that the last one of a scan can be marked.
// After reset (aresetn low, synchronous) all slots are free, the next number
// is 1, counters are zero and registers return to their defaults.
module seq_window_ack_tracker
    import swat_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // command and status between sequencer and datapath
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    swat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swat_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- test/tb_seq_window_ack_tracker.sv -----
// Self-checking testbench for seq_window_ack_tracker: directed and random events
// are run against an in-bench predictor of the slot table. Needs swat_pkg and the RTL.
`timescale 1ns / 100ps

module tb_seq_window_ack_tracker;
    import swat_pkg::*;

    localparam int NSLOT = 64;

    // Status codes of a tracked entry
    typedef enum logic [1:0] {
        ST_WAIT_ACK = 2'd0,
        ST_ACKED    = 2'd1,
        ST_DONE     = 2'd2
    } ack_state_t;

    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    seq_window_ack_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Predictor state: a mirror of the slot table and the registers
    // ---------------------------------------------------------------
    logic [15:0] p_delay;
    logic [5:0]  p_gap;
    logic [6:0]  p_qlim;
    logic [31:0] p_next_seq;
    logic [31:0] p_ticks;
    logic [31:0] p_last_scan;
    logic [6:0]  p_cmd_count;
    logic        tbl_valid  [NSLOT];
    logic        tbl_cmd    [NSLOT];
    ack_state_t  tbl_state  [NSLOT];
    logic        tbl_silent [NSLOT];
    logic [31:0] tbl_seq    [NSLOT];
    logic [7:0]  tbl_type   [NSLOT];
    logic [31:0] tbl_sent   [NSLOT];

    out_item_t awaited_beats[$];   // results still due from the block
    out_item_t event_beats[$];     // results of the event being predicted
    int        fail_count = 0;

    // Receiver control
    bit hold_req = 0;
    bit stall_on = 1;
    int stall_left = 0;

    function automatic void add_beat(logic [3:0] kind, logic [31:0] seq, int slot,
                                     logic cmd, logic [7:0] mt, logic [31:0] dat);
        out_item_t b;
        b.out_kind = kind;
        b.out_seq = seq;
        b.out_slot = slot[5:0];
        b.out_is_command = cmd;
        b.out_msg_type = mt;
        b.out_data = dat;
        b.out_last = 1'b0;
        event_beats.push_back(b);
    endfunction

    function automatic int find_slot(logic cmd, logic [31:0] seq);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && tbl_cmd[i] == cmd && tbl_seq[i] == seq) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int i);
        if (tbl_cmd[i] && p_cmd_count > 0) p_cmd_count--;
        tbl_valid[i] = 1'b0;
    endfunction

    function automatic void predict_issue(in_item_t it);
        logic [31:0] oldest;
        int          free_i;
        oldest = 0;
        free_i = -1;
        if (it.is_command && p_cmd_count >= p_qlim) begin
            add_beat(K_QUEUE_FULL, p_next_seq, 0, 1'b1, it.msg_type, 0);
            return;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_valid[i]) begin
                if (p_next_seq - tbl_seq[i] > oldest) oldest = p_next_seq - tbl_seq[i];
            end else if (free_i < 0) begin
                free_i = i;
            end
        end
        if (oldest > p_gap || free_i < 0) begin
            add_beat(K_WINDOW_FULL, p_next_seq, 0, it.is_command, it.msg_type, 0);
            return;
        end
        tbl_valid[free_i]  = 1'b1;
        tbl_cmd[free_i]    = it.is_command;
        tbl_state[free_i]  = ST_WAIT_ACK;
        tbl_silent[free_i] = it.silent_remove;
        tbl_seq[free_i]    = p_next_seq;
        tbl_type[free_i]   = it.msg_type;
        tbl_sent[free_i]   = p_ticks;
        if (it.is_command) p_cmd_count++;
        add_beat(K_SEND, p_next_seq, free_i, it.is_command, it.msg_type, 0);
        p_next_seq++;
    endfunction

    function automatic void predict_ack(logic cmd, in_item_t it);
        int i;
        i = find_slot(cmd, it.seq_in);
        if (i < 0) begin
            add_beat(K_UNEXPECTED, it.seq_in, 0, cmd, 0, 0);
        end else if (tbl_state[i] == ST_ACKED) begin
            add_beat(K_DUPLICATE, it.seq_in, i, cmd, tbl_type[i], 0);
        end else if (tbl_state[i] != ST_WAIT_ACK) begin
            add_beat(K_LATE_ACK, it.seq_in, i, cmd, tbl_type[i], 0);
        end else begin
            tbl_state[i] = ST_ACKED;
            if (!cmd && tbl_silent[i]) drop_slot(i);
            add_beat(cmd ? K_CMD_ACKED : K_REQ_ACKED, it.seq_in, i, cmd, tbl_type[i],
                     it.ack_data);
        end
    endfunction

    function automatic void predict_finish(in_item_t it);
        int i;
        add_beat(K_FINISH_ACK, it.finish_seq, 0, 1'b1, 0, 0);
        i = find_slot(1'b1, it.seq_in);
        if (i < 0) begin
            add_beat(K_UNEXPECTED, it.seq_in, 0, 1'b1, 0, 0);
        end else if (tbl_state[i] == ST_DONE) begin
            add_beat(K_DUPLICATE, it.seq_in, i, 1'b1, tbl_type[i], 0);
        end else begin
            tbl_state[i] = ST_DONE;
            if (tbl_silent[i]) drop_slot(i);
            add_beat(K_CMD_FINISHED, it.seq_in, i, 1'b1, tbl_type[i], it.ack_data);
        end
    endfunction

    // Scan requests first, then commands; within each, oldest number first.
    function automatic void predict_tick();
        p_ticks++;
        if (p_ticks - p_last_scan < {16'd0, p_delay}) return;
        for (int t = 0; t < 2; t++)
            for (int d = 64; d >= 1; d--)
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_valid[i] && tbl_cmd[i] == t[0] && p_next_seq - tbl_seq[i] == d
                        && tbl_state[i] == ST_WAIT_ACK
                        && p_ticks - tbl_sent[i] >= {16'd0, p_delay})
                        add_beat(K_RETRANSMIT, tbl_seq[i], i, t[0], tbl_type[i], 0);
        p_last_scan = p_ticks;
    endfunction

    function automatic void predict_release(in_item_t it);
        int i;
        i = find_slot(it.is_command, it.seq_in);
        if (i < 0) begin
            add_beat(K_UNEXPECTED, it.seq_in, 0, it.is_command, 0, 0);
        end else begin
            add_beat(K_RELEASED, it.seq_in, i, it.is_command, tbl_type[i], 0);
            drop_slot(i);
        end
    endfunction

    function automatic void predict_event(in_item_t it);
        event_beats.delete();
        case (it.req_type)
            REQ_ISSUE:   predict_issue(it);
            REQ_REQ_ACK: predict_ack(1'b0, it);
            REQ_CMD_ACK: predict_ack(1'b1, it);
            REQ_FINISH:  predict_finish(it);
            REQ_TICK:    predict_tick();
            REQ_RELEASE: predict_release(it);
            default: ;
        endcase
        if (event_beats.size() > 0) event_beats[event_beats.size()-1].out_last = 1'b1;
        foreach (event_beats[k]) awaited_beats.push_back(event_beats[k]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic in_item_t make_item(logic [2:0] rt, logic cmd, logic sil,
                                           logic [7:0] mt, logic [31:0] seq);
        in_item_t it;
        it.req_type = rt;
        it.is_command = cmd;
        it.silent_remove = sil;
        it.msg_type = mt;
        it.seq_in = seq;
        it.finish_seq = $urandom;
        it.ack_data = $urandom;
        return it;
    endfunction

    // Pick a live number of one table, or a random one when the table is empty.
    function automatic logic [31:0] live_seq(logic cmd);
        int hits[$];
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && tbl_cmd[i] == cmd) hits.push_back(i);
        if (hits.size() == 0) return $urandom;
        return tbl_seq[hits[$urandom_range(hits.size()-1)]];
    endfunction

    // Offer one beat, hold it until accepted, predict at the accept edge,
    // then leave a random gap. Called and returns aligned to a rising edge.
    task automatic send_event(in_item_t it);
        int gap;
        int pick;
        s_valid <= 1'b1;
        s_data  <= it;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        predict_event(it);
        pick = $urandom_range(99);
        gap = (pick < 65) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_RETX_DELAY) p_delay = val;
        else if (idx == CFG_MAX_GAP) p_gap = val[5:0];
        else if (idx == CFG_QUEUE_LIMIT) p_qlim = val[6:0];
    endtask

    // Drain all results, then let a full scan's worth of cycles pass.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_beats.size() > 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] dly, logic [5:0] gp, logic [6:0] ql);
        write_reg(CFG_RETX_DELAY, dly);
        write_reg(CFG_MAX_GAP, {10'd0, gp});
        write_reg(CFG_QUEUE_LIMIT, {9'd0, ql});
    endtask

    function automatic in_item_t random_event();
        int pick;
        logic cmd;
        pick = $urandom_range(99);
        cmd = $urandom_range(1);
        if (pick < 30) return make_item(REQ_ISSUE, cmd, $urandom_range(1), $urandom, $urandom);
        if (pick < 45) return make_item(REQ_REQ_ACK, cmd, $urandom_range(1), $urandom,
                                        ($urandom_range(9) < 8) ? live_seq(1'b0) : $urandom);
        if (pick < 57) return make_item(REQ_CMD_ACK, cmd, $urandom_range(1), $urandom,
                                        ($urandom_range(9) < 8) ? live_seq(1'b1) : $urandom);
        if (pick < 69) return make_item(REQ_FINISH, cmd, $urandom_range(1), $urandom,
                                        ($urandom_range(9) < 8) ? live_seq(1'b1) : $urandom);
        if (pick < 82) return make_item(REQ_TICK, cmd, $urandom_range(1), $urandom, $urandom);
        if (pick < 96) return make_item(REQ_RELEASE, cmd, $urandom_range(1), $urandom,
                                        ($urandom_range(9) < 8) ? live_seq(cmd) : $urandom);
        return make_item(REQ_UNUSED_A | 3'($urandom_range(1)), cmd, $urandom_range(1),
                         $urandom, $urandom);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Walk one request and one command through every state, plus the stray cases.
    task automatic test_lifecycle();
        logic [31:0] rq, cq;
        send_event(make_item(REQ_ISSUE, 1'b0, 1'b0, 8'h00, 32'h0));
        rq = p_next_seq - 1;
        send_event(make_item(REQ_ISSUE, 1'b1, 1'b0, 8'hff, 32'hffffffff));
        cq = p_next_seq - 1;
        send_event(make_item(REQ_REQ_ACK, 1'b0, 1'b0, 8'h00, rq));
        send_event(make_item(REQ_REQ_ACK, 1'b0, 1'b0, 8'h00, rq));      // duplicate
        send_event(make_item(REQ_CMD_ACK, 1'b1, 1'b0, 8'h00, cq));
        send_event(make_item(REQ_FINISH, 1'b1, 1'b0, 8'h00, cq));
        send_event(make_item(REQ_CMD_ACK, 1'b1, 1'b0, 8'h00, cq));      // late ack
        send_event(make_item(REQ_FINISH, 1'b1, 1'b0, 8'h00, cq));       // finish again
        send_event(make_item(REQ_REQ_ACK, 1'b0, 1'b0, 8'h00, 32'hffffffff)); // no entry
        send_event(make_item(REQ_FINISH, 1'b1, 1'b0, 8'h00, 32'h0));    // no entry
        send_event(make_item(REQ_RELEASE, 1'b1, 1'b0, 8'h00, cq));
        send_event(make_item(REQ_RELEASE, 1'b0, 1'b0, 8'h00, rq));
        send_event(make_item(REQ_RELEASE, 1'b0, 1'b0, 8'h00, rq));      // already gone
        // Silent entries vanish on completion
        send_event(make_item(REQ_ISSUE, 1'b0, 1'b1, 8'h5a, 32'h0));
        send_event(make_item(REQ_REQ_ACK, 1'b0, 1'b0, 8'h00, p_next_seq - 1));
        send_event(make_item(REQ_ISSUE, 1'b1, 1'b1, 8'ha5, 32'h0));
        send_event(make_item(REQ_FINISH, 1'b1, 1'b0, 8'h00, p_next_seq - 1));
        send_event(make_item(REQ_UNUSED_A, 1'b1, 1'b1, 8'hff, 32'hffffffff));
        send_event(make_item(REQ_UNUSED_B, 1'b0, 1'b0, 8'h00, 32'h0));
        settle();
    endtask

    // Queue limit and gap limit refusals with a gap limit of 0 and a queue limit of 1.
    task automatic test_refusals();
        set_regs(16'd100, 6'd0, 7'd1);
        send_event(make_item(REQ_ISSUE, 1'b1, 1'b0, 8'h11, 32'h0));
        send_event(make_item(REQ_ISSUE, 1'b1, 1'b0, 8'h22, 32'h0));  // queue full
        send_event(make_item(REQ_ISSUE, 1'b0, 1'b0, 8'h33, 32'h0));  // window full
        send_event(make_item(REQ_RELEASE, 1'b1, 1'b0, 8'h00, p_next_seq - 1));
        send_event(make_item(REQ_ISSUE, 1'b0, 1'b0, 8'h44, 32'h0));
        send_event(make_item(REQ_RELEASE, 1'b0, 1'b0, 8'h00, p_next_seq - 1));
        settle();
    endtask

    // Scan on every tick; unacked requests come back before commands, oldest first within each.
    task automatic test_retransmit();
        set_regs(16'd1, 6'd63, 7'd64);
        repeat (3) send_event(make_item(REQ_ISSUE, 1'b1, 1'b0, $urandom, 32'h0));
        repeat (3) send_event(make_item(REQ_ISSUE, 1'b0, 1'b0, $urandom, 32'h0));
        repeat (3) send_event(make_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 32'h0));
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i])
                send_event(make_item(REQ_RELEASE, tbl_cmd[i], 1'b0, 8'h00, tbl_seq[i]));
        send_event(make_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 32'h0));   // nothing to resend
        settle();
    endtask

    // Stall the receiver long while issues keep coming, until the table is full.
    task automatic test_backpressure();
        set_regs(16'hffff, 6'd63, 7'd64);
        hold_req = 1;
        repeat (66) send_event(make_item(REQ_ISSUE, $urandom_range(1), $urandom_range(1),
                                         $urandom, 32'h0));
        settle();
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i])
                send_event(make_item(REQ_RELEASE, tbl_cmd[i], 1'b0, 8'h00, tbl_seq[i]));
        settle();
    endtask

    // Random traffic over several register settings, one with no receiver stalls.
    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_regs(16'd3, 6'd63, 7'd64);
                1: set_regs(16'd1, 6'd8, 7'd2);
                2: set_regs(16'hffff, 6'd0, 7'd1);
                default: set_regs($urandom_range(1, 6), $urandom_range(63),
                                  $urandom_range(1, 64));
            endcase
            stall_on = (ph != 3);
            repeat (46) send_event(random_event());
            settle();
        end
        stall_on = 1;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off when asked
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (stall_on && $urandom_range(9) < 3)
                    stall_left = ($urandom_range(9) < 9) ? $urandom_range(1, 3)
                                                         : $urandom_range(15, 40);
            end
        end
    end

    // Check every beat against the oldest outstanding result.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                $error("result beat with nothing outstanding: kind %0d seq %0h",
                       m_data.out_kind, m_data.out_seq);
                fail_count++;
            end else begin
                want = awaited_beats.pop_front();
                if (m_data.out_kind !== want.out_kind) begin
                    $error("out_kind: expected %0d, got %0d", want.out_kind, m_data.out_kind);
                    fail_count++;
                end
                if (m_data.out_seq !== want.out_seq) begin
                    $error("out_seq: expected %0h, got %0h", want.out_seq, m_data.out_seq);
                    fail_count++;
                end
                if (m_data.out_slot !== want.out_slot) begin
                    $error("out_slot: expected %0d, got %0d", want.out_slot, m_data.out_slot);
                    fail_count++;
                end
                if (m_data.out_is_command !== want.out_is_command) begin
                    $error("out_is_command: expected %0b, got %0b",
                           want.out_is_command, m_data.out_is_command);
                    fail_count++;
                end
                if (m_data.out_msg_type !== want.out_msg_type) begin
                    $error("out_msg_type: expected %0h, got %0h",
                           want.out_msg_type, m_data.out_msg_type);
                    fail_count++;
                end
                if (m_data.out_data !== want.out_data) begin
                    $error("out_data: expected %0h, got %0h", want.out_data, m_data.out_data);
                    fail_count++;
                end
                if (m_data.out_last !== want.out_last) begin
                    $error("out_last: expected %0b, got %0b", want.out_last, m_data.out_last);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        p_delay = DELAY_RST;
        p_gap = GAP_RST;
        p_qlim = QLIM_RST;
        p_next_seq = 32'd1;
        p_ticks = '0;
        p_last_scan = '0;
        p_cmd_count = '0;
        for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_lifecycle();
        test_refusals();
        test_retransmit();
        test_backpressure();
        test_random();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
